@@ sv/assert_macros.svh @@
// Assertion macros shared by the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge, masked while rst is high.
`define CHECK_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define CHECK_NEVER(label, cond, msg) `CHECK_PROP(label, !(cond), msg)

`endif

@@ sv/sexpr_tok_pkg.sv @@
// Types, character codes and helper functions for the token scanner.
`timescale 1ns / 1ps

package sexpr_tok_pkg;

  localparam int HOLD_LEN    = 5;
  localparam int MAX_RESULTS = 7;

  localparam logic [7:0] CHAR_OPEN   = 8'h28;
  localparam logic [7:0] CHAR_CLOSE  = 8'h29;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_NL     = 8'h0a;
  localparam logic [7:0] CHAR_SEMI   = 8'h3b;
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_VTAB   = 8'h0b;
  localparam logic [7:0] CHAR_FF     = 8'h0c;
  localparam logic [7:0] CHAR_CR     = 8'h0d;
  localparam logic [7:0] CHAR_NUL    = 8'h00;

  // Keyword text, entry 0 is the first character of the word.
  localparam logic [HOLD_LEN-1:0][7:0] KEYWORD = {8'h65, 8'h74, 8'h6f, 8'h75, 8'h71};

  typedef enum logic [2:0] {
    KIND_OPEN  = 3'd0,
    KIND_CLOSE = 3'd1,
    KIND_QUOTE = 3'd2,
    KIND_NL    = 3'd3,
    KIND_WBYTE = 3'd4,
    KIND_WEND  = 3'd5,
    KIND_END   = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    CL_OPEN, CL_CLOSE, CL_QUOTE, CL_NL, CL_REMARK, CL_SPACE, CL_END, CL_WORD
  } class_t;

  // One burst of results produced by a single input request.
  typedef struct packed {
    logic [2:0]                        count;
    kind_t [MAX_RESULTS-1:0]           kind;
    logic  [MAX_RESULTS-1:0][7:0]      chr;
  } burst_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } tok_t;

  function automatic class_t classify(input logic [7:0] ch, input logic ended);
    class_t cl;
    if (ended || ch == CHAR_NUL) begin
      cl = CL_END;
    end else begin
      case (ch)
        CHAR_OPEN:                                   cl = CL_OPEN;
        CHAR_CLOSE:                                  cl = CL_CLOSE;
        CHAR_DQUOTE, CHAR_SQUOTE:                    cl = CL_QUOTE;
        CHAR_NL:                                     cl = CL_NL;
        CHAR_SEMI, CHAR_HASH:                        cl = CL_REMARK;
        CHAR_SPACE, CHAR_TAB, CHAR_VTAB, CHAR_FF,
        CHAR_CR:                                     cl = CL_SPACE;
        default:                                     cl = CL_WORD;
      endcase
    end
    return cl;
  endfunction

  // Single-token classes seen between words.
  function automatic tok_t idle_token(input class_t cl);
    tok_t t;
    t.valid = 1'b1;
    case (cl)
      CL_OPEN:  t.kind = KIND_OPEN;
      CL_CLOSE: t.kind = KIND_CLOSE;
      CL_QUOTE: t.kind = KIND_QUOTE;
      CL_NL:    t.kind = KIND_NL;
      CL_END:   t.kind = KIND_END;
      default: begin
        t.valid = 1'b0;
        t.kind  = KIND_OPEN;
      end
    endcase
    return t;
  endfunction

endpackage

@@ sv/sexpr_tok_burst.sv @@
// Result burst register: loads up to seven results and drains one per cycle while out_stall is low.
`timescale 1ns / 1ps

module sexpr_tok_burst (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  sexpr_tok_pkg::burst_t  load_data,
  output logic                   can_load,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             kind,
  output logic [7:0]             word_char,
  output logic                   last
);

  sexpr_tok_pkg::burst_t pend;
  sexpr_tok_pkg::burst_t pend_next;
  logic                  take;

  assign out_valid = (pend.count != 3'd0);
  assign take      = out_valid && !out_stall;
  // free once the last pending result leaves this cycle
  assign can_load  = (pend.count == 3'd0) || (pend.count == 3'd1 && take);

  assign kind      = pend.kind[0];
  assign word_char = pend.chr[0];
  assign last      = (pend.count == 3'd1);

  always_comb begin
    pend_next = pend;
    if (load) begin
      pend_next = load_data;
    end else if (take) begin
      for (int i = 0; i < sexpr_tok_pkg::MAX_RESULTS - 1; i++) begin
        pend_next.kind[i] = pend.kind[i+1];
        pend_next.chr[i]  = pend.chr[i+1];
      end
      pend_next.count = pend.count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    pend.kind <= pend_next.kind;
    pend.chr  <= pend_next.chr;
    if (rst) begin
      pend.count <= 3'd0;
    end else begin
      pend.count <= pend_next.count;
    end
  end

endmodule

@@ sv/sexpr_tok_scanner_unit.sv @@
// Top level of the list-syntax token scanner.
// Path: an accepted request is captured in the input register and is loaded into the
//   burst register once that is free; its first result is then valid at the output.
// Throughput: one request per cycle while each yields at most one result and out_stall is
//   low; a request yielding n results holds the output burst register until all n drain (n up to 7).
// Structure: input register -> one pass of scan logic -> result burst register.
// Reset (rst, synchronous): scanner between tokens, no held word, both registers empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sexpr_token_scanner_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] kind,
  output logic [7:0] word_char,
  output logic       last
);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_WORD    = 2'd1,
    MODE_COMMENT = 2'd2
  } mode_t;

  localparam int HL = sexpr_tok_pkg::HOLD_LEN;

  // Input register: holds a request while the burst register is still busy.
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_end;

  // Scanner state.
  mode_t              scan_mode;
  mode_t              scan_mode_next;
  logic [HL-1:0][7:0] prefix_chars;
  logic [2:0]         prefix_count;
  logic [2:0]         prefix_count_next;
  logic               past_prefix;
  logic               past_prefix_next;
  logic               prefix_wr;
  logic               word_held;

  logic                  accept;
  logic                  move;
  logic                  can_load;
  sexpr_tok_pkg::class_t cl;
  sexpr_tok_pkg::tok_t   idle_tok;
  sexpr_tok_pkg::burst_t scan_load;
  logic                  is_keyword;

  // Burst assembly: hf held word bytes, then up to two trailing tokens.
  logic [2:0]           hf;
  logic                 t0_valid;
  sexpr_tok_pkg::kind_t t0_kind;
  logic [7:0]           t0_char;
  logic                 t1_valid;
  sexpr_tok_pkg::kind_t t1_kind;

  assign in_stall = in_full && !can_load;
  assign accept   = in_valid && !in_stall;
  assign move     = in_full && can_load;

  assign cl         = sexpr_tok_pkg::classify(in_byte, in_end);
  assign idle_tok   = sexpr_tok_pkg::idle_token(cl);
  assign is_keyword = !past_prefix && (prefix_count == 3'(HL)) &&
                      (prefix_chars == sexpr_tok_pkg::KEYWORD);
  assign word_held  = past_prefix || (prefix_count != 3'd0);

  // Scan decision for the request in the input register.
  always_comb begin
    scan_mode_next    = scan_mode;
    prefix_count_next = prefix_count;
    past_prefix_next  = past_prefix;
    prefix_wr         = 1'b0;
    hf                = 3'd0;
    t0_valid          = 1'b0;
    t0_kind           = sexpr_tok_pkg::KIND_OPEN;
    t0_char           = 8'd0;
    t1_valid          = 1'b0;
    t1_kind           = sexpr_tok_pkg::KIND_OPEN;
    case (scan_mode)
      MODE_WORD: begin
        if (cl == sexpr_tok_pkg::CL_WORD) begin
          if (past_prefix) begin
            t0_valid = 1'b1;
            t0_kind  = sexpr_tok_pkg::KIND_WBYTE;
            t0_char  = in_byte;
          end else if (prefix_count < 3'(HL)) begin
            prefix_wr         = 1'b1;
            prefix_count_next = prefix_count + 3'd1;
          end else begin
            // sixth byte: flush the held prefix and stream from here on
            hf                = prefix_count;
            t0_valid          = 1'b1;
            t0_kind           = sexpr_tok_pkg::KIND_WBYTE;
            t0_char           = in_byte;
            past_prefix_next  = 1'b1;
            prefix_count_next = 3'd0;
          end
        end else begin
          t0_valid = 1'b1;
          if (is_keyword) begin
            t0_kind = sexpr_tok_pkg::KIND_QUOTE;
          end else begin
            hf      = past_prefix ? 3'd0 : prefix_count;
            t0_kind = sexpr_tok_pkg::KIND_WEND;
          end
          prefix_count_next = 3'd0;
          past_prefix_next  = 1'b0;
          scan_mode_next    = MODE_IDLE;
          // a quote mark that ends a word is dropped
          if (cl != sexpr_tok_pkg::CL_QUOTE) begin
            t1_valid = idle_tok.valid;
            t1_kind  = idle_tok.kind;
            if (cl == sexpr_tok_pkg::CL_REMARK) begin
              scan_mode_next = MODE_COMMENT;
            end
          end
        end
      end
      MODE_COMMENT: begin
        if (cl == sexpr_tok_pkg::CL_NL || cl == sexpr_tok_pkg::CL_END) begin
          t0_valid       = 1'b1;
          t0_kind        = idle_tok.kind;
          scan_mode_next = MODE_IDLE;
        end
      end
      default: begin
        // between tokens; the unused mode code behaves the same
        scan_mode_next = MODE_IDLE;
        t0_valid       = idle_tok.valid;
        t0_kind        = idle_tok.kind;
        if (cl == sexpr_tok_pkg::CL_REMARK) begin
          scan_mode_next = MODE_COMMENT;
        end else if (cl == sexpr_tok_pkg::CL_WORD) begin
          scan_mode_next    = MODE_WORD;
          past_prefix_next  = 1'b0;
          prefix_wr         = 1'b1;
          prefix_count_next = 3'd1;
        end
      end
    endcase
  end

  // Lay the burst out: held bytes first, then the trailing tokens.
  always_comb begin
    for (int i = 0; i < sexpr_tok_pkg::MAX_RESULTS; i++) begin
      scan_load.kind[i] = sexpr_tok_pkg::KIND_OPEN;
      scan_load.chr[i]  = 8'd0;
    end
    for (int i = 0; i < HL; i++) begin
      if (3'(i) < hf) begin
        scan_load.kind[i] = sexpr_tok_pkg::KIND_WBYTE;
        scan_load.chr[i]  = prefix_chars[i];
      end
    end
    if (t0_valid) begin
      scan_load.kind[hf] = t0_kind;
      scan_load.chr[hf]  = t0_char;
    end
    if (t1_valid) begin
      scan_load.kind[hf + 3'd1] = t1_kind;
      scan_load.chr[hf + 3'd1]  = 8'd0;
    end
    scan_load.count = hf + 3'(t0_valid) + 3'(t1_valid);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= text_byte;
      in_end  <= end_of_input;
    end
    // first word byte goes to entry 0 since the count restarts there
    for (int i = 0; i < HL; i++) begin
      if (move && prefix_wr &&
          3'(i) == ((scan_mode == MODE_WORD) ? prefix_count : 3'd0)) begin
        prefix_chars[i] <= in_byte;
      end
    end
    if (rst) begin
      in_full      <= 1'b0;
      scan_mode    <= MODE_IDLE;
      prefix_count <= 3'd0;
      past_prefix  <= 1'b0;
    end else begin
      if (accept) begin
        in_full <= 1'b1;
      end else if (move) begin
        in_full <= 1'b0;
      end
      if (move) begin
        scan_mode    <= scan_mode_next;
        prefix_count <= prefix_count_next;
        past_prefix  <= past_prefix_next;
      end
    end
  end

  sexpr_tok_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .load      (move),
    .load_data (scan_load),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .word_char (word_char),
    .last      (last)
  );

  // Held prefix never overflows, and streaming mode keeps no held bytes.
  `CHECK_NEVER(a_prefix_range, prefix_count > 3'(HL), "prefix count beyond hold length")
  `CHECK_NEVER(a_stream_no_hold, past_prefix && prefix_count != 3'd0, "held bytes in stream")
  `CHECK_NEVER(a_comment_clean, scan_mode == MODE_COMMENT && word_held, "word state in comment")
  // A non-empty burst loaded must show up at the output next cycle.
  `CHECK_PROP(a_burst_shown, (move && scan_load.count != 3'd0) |=> out_valid, "burst not shown")

endmodule
